@@ hw/rtl/khm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_pkg: shared types for the k-way heap merge core
// Request and status codes and the queue entry between front and engine.
// ----------------------------------------------------------------------------
package khm_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_LOADED    = 3'd0,
		STS_POPPED    = 3'd1,
		STS_EXHAUSTED = 3'd2,
		STS_FULL      = 3'd3,
		STS_REFUSED   = 3'd4,
		STS_CLEARED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_SCAN,
		ENG_READ,
		ENG_FILL,
		ENG_DONE
	} eng_state_t;

	// One classified transaction waiting for the engine.
	typedef struct packed {
		req_t        req;
		logic [2:0]  list_id;
		logic [31:0] value;
	} cmd_t;

endpackage

@@ hw/rtl/khm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_front: request intake
// Accepts input transactions, drops the unused request code and queues the
// rest in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module khm_front import khm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [2:0]         list_id,
	input  logic signed [31:0] value,
	output logic               q_valid,
	input  logic               q_ready,
	output cmd_t               q_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	// The queue has room unless both entries hold work.
	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready && (req_t'(req_type) != REQ_NONE);
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = entry_q[rd_ptr_q];

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{req: req_t'(req_type), list_id: list_id, value: value};
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ hw/rtl/khm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_engine: merge engine
// Holds the element memory, per-list fill and read counters and the current
// head of each list, scans the heads for the smallest one on a pop, refills
// the head from memory and drives the result register.
// ----------------------------------------------------------------------------
module khm_engine import khm_pkg::*; #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  cmd_t               q_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] merged_value,
	output logic [2:0]         status
);

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int MD = NUM_LISTS * LIST_DEPTH;
	localparam int AW = (MD > 1) ? $clog2(MD) : 1;

	eng_state_t state_q, state_d;

	logic [31:0]   mem [MD];
	logic [31:0]   rd_data_q;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0] fill_q [NUM_LISTS];
	logic [CW-1:0] rdpos_q [NUM_LISTS];
	logic [31:0]   head_q [NUM_LISTS];
	logic          merging_q;

	cmd_t          cur_q;
	logic [LW-1:0] scan_q;
	logic          best_vld_q;
	logic [31:0]   best_val_q;
	logic [LW-1:0] best_src_q;

	logic [31:0]   res_val_q;
	status_t       res_sts_q;
	logic          out_valid_q;
	logic [31:0]   out_val_q;
	status_t       out_sts_q;

	logic          id_ok;
	logic [LW-1:0] load_idx;
	logic          list_full;
	logic          scan_live;
	logic          scan_wins;
	logic          scan_last;
	logic [CW-1:0] pos_next;
	logic          has_more;
	logic          emit;
	logic          take;

	// Load decode.
	assign id_ok     = (32'(cur_q.list_id) < NUM_LISTS);
	assign load_idx  = LW'(32'(cur_q.list_id));
	assign list_full = (32'(fill_q[load_idx]) >= LIST_DEPTH);

	// Scan compare: strict less keeps the lower list index on equal values.
	assign scan_live = (rdpos_q[scan_q] < fill_q[scan_q]);
	assign scan_wins = scan_live && (!best_vld_q ||
		($signed(head_q[scan_q]) < $signed(best_val_q)));
	assign scan_last = (scan_q == LW'(NUM_LISTS - 1));

	// Refill address for the list that just gave its head.
	assign pos_next = rdpos_q[best_src_q] + CW'(1);
	assign has_more = (pos_next < fill_q[best_src_q]);
	assign rd_addr  = AW'(32'(best_src_q) * LIST_DEPTH + 32'(pos_next));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (q_valid) begin
					state_d = ENG_SCAN;
				end
			end
			ENG_SCAN: begin
				if (cur_q.req != REQ_POP) begin
					state_d = ENG_DONE;
				end else if (scan_last) begin
					state_d = (best_vld_q || scan_wins) ? ENG_READ : ENG_DONE;
				end
			end
			ENG_READ: state_d = has_more ? ENG_FILL : ENG_DONE;
			ENG_FILL: state_d = ENG_DONE;
			ENG_DONE: begin
				if (emit) begin
					state_d = ENG_IDLE;
				end
			end
			default:  state_d = ENG_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		q_ready = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			ENG_IDLE: q_ready = 1'b1;
			ENG_DONE: emit    = !out_valid_q || out_ready;
			default: begin
				q_ready = 1'b0;
				emit    = 1'b0;
			end
		endcase
	end

	assign take = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Element memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ENG_SCAN && cur_q.req == REQ_LOAD && !merging_q && id_ok &&
			!list_full) begin
			mem[AW'(32'(load_idx) * LIST_DEPTH + 32'(fill_q[load_idx]))] <= cur_q.value;
		end
		if (state_q == ENG_READ) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Transaction capture, scan tracking and list heads.
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_cmd;
		end
		if (state_q == ENG_SCAN && scan_wins) begin
			best_val_q <= head_q[scan_q];
			best_src_q <= scan_q;
		end
		if (state_q == ENG_SCAN && cur_q.req == REQ_LOAD && !merging_q && id_ok &&
			!list_full && fill_q[load_idx] == '0) begin
			head_q[load_idx] <= cur_q.value;
		end
		if (state_q == ENG_FILL) begin
			head_q[best_src_q] <= rd_data_q;
		end
	end

	// Result of the transaction in progress.
	always_ff @(posedge clk) begin
		if (state_q == ENG_SCAN) begin
			res_val_q <= '0;
			case (cur_q.req)
				REQ_LOAD: begin
					if (merging_q) begin
						res_sts_q <= STS_REFUSED;
					end else if (!id_ok || list_full) begin
						res_sts_q <= STS_FULL;
					end else begin
						res_sts_q <= STS_LOADED;
					end
				end
				REQ_CLEAR: res_sts_q <= STS_CLEARED;
				default:   res_sts_q <= STS_EXHAUSTED;
			endcase
		end
		if (state_q == ENG_READ) begin
			res_val_q <= best_val_q;
			res_sts_q <= STS_POPPED;
		end
	end

	// Counters, merge flag and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				fill_q[i]  <= '0;
				rdpos_q[i] <= '0;
			end
			merging_q  <= 1'b0;
			scan_q     <= '0;
			best_vld_q <= 1'b0;
		end else begin
			if (take) begin
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end
			if (state_q == ENG_SCAN) begin
				case (cur_q.req)
					REQ_LOAD: begin
						if (!merging_q && id_ok && !list_full) begin
							fill_q[load_idx] <= fill_q[load_idx] + CW'(1);
						end
					end
					REQ_CLEAR: begin
						for (int i = 0; i < NUM_LISTS; i++) begin
							fill_q[i]  <= '0;
							rdpos_q[i] <= '0;
						end
						merging_q <= 1'b0;
					end
					default: begin
						merging_q <= 1'b1;
						if (scan_wins) begin
							best_vld_q <= 1'b1;
						end
						if (!scan_last) begin
							scan_q <= scan_q + LW'(1);
						end
					end
				endcase
			end
			if (state_q == ENG_READ) begin
				rdpos_q[best_src_q] <= pos_next;
			end
		end
	end

	// Output register: a finished result waits here while the next one is built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_val_q <= res_val_q;
			out_sts_q <= res_sts_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_value = out_val_q;
	assign status       = out_sts_q;

endmodule

@@ hw/rtl/k_way_heap_merge_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_heap_merge_core: k-way merge of ascending lists
// Loads append signed values to lists; pops return the merged ascending order.
// ----------------------------------------------------------------------------
// A load or clear passes from intake through the engine's scan and done states.
// A pop scans every list head, one list head per cycle; if it finds an element
// it goes on through a registered read of the element memory, a refill of the
// popped list's head when that list has a next element, and the done state.
// A pop that finds nothing left goes from the scan straight to the done state.
// A two-entry queue takes new transactions while the engine works, and the
// result register holds a finished result while the next one is built. Equal
// values come out in order of list index. Reset needs no clearing pass.
module k_way_heap_merge_core import khm_pkg::*; #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [2:0]         list_id,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] merged_value,
	output logic [2:0]         status
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	// Intake and queue.
	khm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.list_id  (list_id),
		.value    (value),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	// Merge engine with result register.
	khm_engine #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cmd        (q_cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.merged_value (merged_value),
		.status       (status)
	);

endmodule

@@ hw/rtl/khm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_checker: port-level checks for the merge core
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module khm_checker import khm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] merged_value,
	input logic [2:0]         status
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_value) && $stable(status))
		else $error("result changed while stalled");

	// Only a pop that found an element carries a nonzero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_POPPED |-> merged_value == 32'sd0)
		else $error("nonzero value on a result without an element");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STS_CLEARED)
		else $error("undefined status code");

endmodule

bind k_way_heap_merge_core khm_checker u_khm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.merged_value (merged_value),
	.status       (status)
);
